// ===== rtl/core/cbpe_pkg.sv =====
package cbpe_pkg;

  // Default coordinate width (Q11.8)
  localparam int DEF_COORD_WIDTH = 20;

  // Curve parameter, Q1.16 with one as 65536
  localparam int          T_W   = 17;
  localparam logic [16:0] T_ONE = 17'd65536;

  // Result widths
  localparam int          SLOPE_W  = 24;
  localparam int          HEAD_W   = 16;
  localparam int          CURV_W   = 24;
  localparam logic [23:0] CURV_MAX = 24'hFF_FFFF;

  // Curvature datapath: derivatives are floored to 24 bits of magnitude
  localparam int FIT_W   = 24;
  localparam int T_SCALE = 14;  // N*2^14/S
  localparam int Q_SCALE = 17;  // T*2^17/R
  localparam int T_QW    = 39;  // quotient bits of N*2^14/S
  localparam int Q_QW    = 49;  // quotient bits of T*2^17/R

  // Heading CORDIC, angles in 1/4096 degree
  localparam int                 CORDIC_STEPS = 16;
  localparam int                 NORM_BL      = 41;
  localparam int                 ANG_W        = 21;
  localparam logic signed [20:0] DEG90_Q12    = 21'sd368640;
  localparam logic signed [20:0] DEG180_Q12   = 21'sd737280;
  localparam int                 HEAD_LAT     = CORDIC_STEPS + 3;

  localparam logic signed [20:0] ATAN_Q12 [CORDIC_STEPS] = '{
    21'sd184320, 21'sd108810, 21'sd57492, 21'sd29184,
    21'sd14649,  21'sd7331,   21'sd3667,  21'sd1833,
    21'sd917,    21'sd458,    21'sd229,   21'sd115,
    21'sd57,     21'sd29,     21'sd14,    21'sd7
  };

  // Special direction cases travelling with the CORDIC
  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic dx_zero;
    logic dy_zero;
  } hdg_flags_t;

endpackage

// ===== rtl/core/cbpe_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// The caller passes the numerator as an initial remainder (below the
// divisor) and the low bits still to be brought down.
module cbpe_div import cbpe_pkg::*; #(
  parameter int QW  = T_QW,
  parameter int DVW = 2 * (FIT_W + 1)
) (
  input  logic           clk,
  input  logic [DVW-1:0] rem0,
  input  logic [QW-1:0]  low,
  input  logic [DVW-1:0] dvs,
  output logic [QW-1:0]  quo
);

  logic [DVW-1:0] rem_q [QW];
  logic [QW-1:0]  low_q [QW];
  logic [DVW-1:0] dvs_q [QW];
  logic [QW-1:0]  quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DVW-1:0] rem_in;
    logic [DVW-1:0] dvs_in;
    logic [QW-1:0]  low_in;
    logic [QW-1:0]  quo_in;
    logic [DVW:0]   trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_in = rem0;
      assign dvs_in = dvs;
      assign low_in = low;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign dvs_in = dvs_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // bring down one bit, subtract when it fits
    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk) begin
      rem_q[i] <= ge ? DVW'(trial - {1'b0, dvs_in}) : trial[DVW-1:0];
      low_q[i] <= low_in << 1;
      dvs_q[i] <= dvs_in;
      quo_q[i] <= {quo_in[QW-2:0], ge};
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ===== rtl/core/cbpe_heading.sv =====
// atan2(dx, dy) from the y axis, 1/128 degree.
// Normalise, then one CORDIC vectoring step per stage.
module cbpe_heading import cbpe_pkg::*; #(
  parameter int DXW = DEF_COORD_WIDTH + 3
) (
  input  logic                     clk,
  input  logic signed [DXW-1:0]    dx,
  input  logic signed [DXW-1:0]    dy,
  output logic signed [HEAD_W-1:0] heading
);

  localparam int NBW = (DXW > NORM_BL) ? DXW : NORM_BL;
  localparam int CW  = NBW + 3;
  localparam int BLW = $clog2(NBW + 1);

  // Stage A: magnitudes, flags, normalising shift
  logic [DXW-1:0] mag_a, mag_b, a_a, b_a;
  logic [BLW-1:0] bl, sh_a;
  hdg_flags_t     fl_a;

  always_comb begin
    mag_a = dy[DXW-1] ? DXW'(-dy) : dy;
    mag_b = dx[DXW-1] ? DXW'(-dx) : dx;
    bl    = '0;
    for (int i = 0; i < DXW; i++) begin
      if (mag_a[i] | mag_b[i]) begin
        bl = BLW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    a_a          <= mag_a;
    b_a          <= mag_b;
    sh_a         <= (bl >= BLW'(NORM_BL)) ? '0 : BLW'(NORM_BL) - bl;
    fl_a.dx_neg  <= dx[DXW-1];
    fl_a.dy_neg  <= dy[DXW-1];
    fl_a.dx_zero <= (dx == '0);
    fl_a.dy_zero <= (dy == '0);
  end

  // Stage B and CORDIC steps
  logic signed [CW-1:0]    ia [CORDIC_STEPS+1];
  logic signed [CW-1:0]    ib [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z  [CORDIC_STEPS+1];
  hdg_flags_t              fl [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    ia[0] <= CW'(a_a) << sh_a;
    ib[0] <= CW'(b_a) << sh_a;
    z[0]  <= '0;
    fl[0] <= fl_a;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!ib[i][CW-1]) begin
        ia[i+1] <= ia[i] + (ib[i] >>> i);
        ib[i+1] <= ib[i] - (ia[i] >>> i);
        z[i+1]  <= z[i] + ATAN_Q12[i];
      end else begin
        ia[i+1] <= ia[i] - (ib[i] >>> i);
        ib[i+1] <= ib[i] + (ia[i] >>> i);
        z[i+1]  <= z[i] - ATAN_Q12[i];
      end
      fl[i+1] <= fl[i];
    end
  end

  // Final: clamp, axis cases, quadrant, round on magnitude, sign
  logic signed [ANG_W-1:0] z_end, z_sel, z_quad, z_rnd;
  hdg_flags_t              fl_end;

  always_comb begin
    z_end  = z[CORDIC_STEPS];
    fl_end = fl[CORDIC_STEPS];
    if (z_end < 0) begin
      z_sel = '0;
    end else if (z_end > DEG90_Q12) begin
      z_sel = DEG90_Q12;
    end else begin
      z_sel = z_end;
    end
    if (fl_end.dx_zero) begin
      z_sel = '0;
    end else if (fl_end.dy_zero) begin
      z_sel = DEG90_Q12;
    end
    z_quad = fl_end.dy_neg ? DEG180_Q12 - z_sel : z_sel;
    z_rnd  = (z_quad + 21'sd16) >>> 5;
  end

  always_ff @(posedge clk) begin
    heading <= fl_end.dx_neg ? HEAD_W'(-z_rnd) : HEAD_W'(z_rnd);
  end

endmodule

// ===== rtl/core/cubic_bezier_point_evaluator_unit.sv =====
// Cubic Bezier point, slope, heading and curvature, fully pipelined.
// Throughput: one evaluation per clock; busy is never raised.
// The pipeline depth is dominated by the
// two bit-per-stage dividers of the curvature path (39 + 49 stages).
// Reset (rst, synchronous) clears only the valid pipeline; results cannot be stalled.
module cubic_bezier_point_evaluator_unit import cbpe_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] p0_x,
  input  logic signed [COORD_WIDTH-1:0] p0_y,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p3_x,
  input  logic signed [COORD_WIDTH-1:0] p3_y,
  input  logic [T_W-1:0]                t_frac,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] pos_x,
  output logic signed [COORD_WIDTH-1:0] pos_y,
  output logic signed [SLOPE_W-1:0]     slope_x,
  output logic signed [SLOPE_W-1:0]     slope_y,
  output logic signed [HEAD_W-1:0]      heading,
  output logic [CURV_W-1:0]             curvature_mag,
  output logic                          degenerate
);

  localparam int W        = COORD_WIDTH;
  localparam int DXW      = W + 3;
  localparam int DDW      = W + 5;
  localparam int PW       = W + T_W + 2;
  localparam int KW       = $clog2(DDW + 1);
  localparam int AW       = FIT_W + 1;
  localparam int NW       = 2 * AW;
  localparam int N1W      = NW + T_SCALE;
  localparam int SQ_STEPS = N1W / 2;
  localparam int SQ_RW    = SQ_STEPS + 3;
  localparam int N2W      = T_QW + Q_SCALE;
  localparam int SIDE_W   = 2 * KW + 2 * W + 2 * SLOPE_W + 1;
  localparam int SIDE_DLY = 3 + T_QW + Q_QW;
  localparam int HEAD_DLY = 4 + T_QW + Q_QW - HEAD_LAT;
  localparam int R_DLY    = T_QW - SQ_STEPS;
  localparam int TOTAL    = 9 + T_QW + Q_QW;

  localparam logic signed [PW-1:0] LERP_HALF = PW'(32768);
  localparam int                   EW        = DXW + SLOPE_W;
  localparam logic signed [EW-1:0] SLOPE_HI  = EW'((2 ** (SLOPE_W - 1)) - 1);
  localparam logic signed [EW-1:0] SLOPE_LO  = EW'(-(2 ** (SLOPE_W - 1)));

  function automatic logic signed [W-1:0] lerp(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b,
                                               input logic [T_W-1:0] t);
    logic signed [W:0]    df;
    logic signed [PW-1:0] pr;
    logic signed [PW-1:0] rs;
    df = {b[W-1], b} - {a[W-1], a};
    pr = df * $signed({1'b0, t});
    rs = (pr + LERP_HALF) >>> 16;
    return a + W'(rs);
  endfunction

  function automatic logic signed [DXW-1:0] slope_of(input logic signed [W-1:0] r0,
                                                     input logic signed [W-1:0] r1);
    logic signed [DXW-1:0] e;
    e = DXW'(r1) - DXW'(r0);
    return (e <<< 1) + e;
  endfunction

  function automatic logic signed [DDW-1:0] accel_of(input logic signed [W-1:0] q0,
                                                     input logic signed [W-1:0] q1,
                                                     input logic signed [W-1:0] q2);
    logic signed [DDW-1:0] e;
    e = DDW'(q2) + DDW'(q0) - (DDW'(q1) <<< 1);
    return (e <<< 2) + (e <<< 1);
  endfunction

  function automatic logic [DDW-1:0] mag_dd(input logic signed [DDW-1:0] v);
    return v[DDW-1] ? DDW'(-v) : v;
  endfunction

  function automatic logic [DDW-1:0] mag_dx(input logic signed [DXW-1:0] v);
    logic [DXW-1:0] m;
    m = v[DXW-1] ? DXW'(-v) : v;
    return DDW'(m);
  endfunction

  // shift that floors a magnitude below 2^24
  function automatic logic [KW-1:0] fit_k(input logic [DDW-1:0] m);
    logic [KW-1:0] bl;
    bl = '0;
    for (int i = 0; i < DDW; i++) begin
      if (m[i]) begin
        bl = KW'(i + 1);
      end
    end
    return (bl > KW'(FIT_W)) ? bl - KW'(FIT_W) : '0;
  endfunction

  function automatic logic signed [SLOPE_W-1:0] sat_slope(input logic signed [DXW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    if (e > SLOPE_HI) begin
      e = SLOPE_HI;
    end else if (e < SLOPE_LO) begin
      e = SLOPE_LO;
    end
    return SLOPE_W'(e);
  endfunction

  assign busy = 1'b0;

  // Valid pipeline
  logic [TOTAL-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL-2:0], start};
    end
  end

  // S0: capture, clamp t
  logic signed [W-1:0] s0_px [4];
  logic signed [W-1:0] s0_py [4];
  logic [T_W-1:0]      s0_t;

  always_ff @(posedge clk) begin
    s0_px[0] <= p0_x;
    s0_py[0] <= p0_y;
    s0_px[1] <= p1_x;
    s0_py[1] <= p1_y;
    s0_px[2] <= p2_x;
    s0_py[2] <= p2_y;
    s0_px[3] <= p3_x;
    s0_py[3] <= p3_y;
    s0_t     <= (t_frac > T_ONE) ? T_ONE : t_frac;
  end

  // S1: first de Casteljau level
  logic signed [W-1:0] s1_qx [3];
  logic signed [W-1:0] s1_qy [3];
  logic [T_W-1:0]      s1_t;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_qx[i] <= lerp(s0_px[i], s0_px[i+1], s0_t);
      s1_qy[i] <= lerp(s0_py[i], s0_py[i+1], s0_t);
    end
    s1_t <= s0_t;
  end

  // S2: second level and second derivative
  logic signed [W-1:0]   s2_r0x, s2_r0y, s2_r1x, s2_r1y;
  logic signed [DDW-1:0] s2_ddx, s2_ddy;
  logic [T_W-1:0]        s2_t;

  always_ff @(posedge clk) begin
    s2_r0x <= lerp(s1_qx[0], s1_qx[1], s1_t);
    s2_r0y <= lerp(s1_qy[0], s1_qy[1], s1_t);
    s2_r1x <= lerp(s1_qx[1], s1_qx[2], s1_t);
    s2_r1y <= lerp(s1_qy[1], s1_qy[2], s1_t);
    s2_ddx <= accel_of(s1_qx[0], s1_qx[1], s1_qx[2]);
    s2_ddy <= accel_of(s1_qy[0], s1_qy[1], s1_qy[2]);
    s2_t   <= s1_t;
  end

  // S3: point and first derivative
  logic signed [W-1:0]   s3_px, s3_py;
  logic signed [DXW-1:0] s3_dx, s3_dy;
  logic signed [DDW-1:0] s3_ddx, s3_ddy;

  always_ff @(posedge clk) begin
    s3_px  <= lerp(s2_r0x, s2_r1x, s2_t);
    s3_py  <= lerp(s2_r0y, s2_r1y, s2_t);
    s3_dx  <= slope_of(s2_r0x, s2_r1x);
    s3_dy  <= slope_of(s2_r0y, s2_r1y);
    s3_ddx <= s2_ddx;
    s3_ddy <= s2_ddy;
  end

  // Heading runs alongside
  logic signed [HEAD_W-1:0] hdg_raw;

  cbpe_heading #(
    .DXW(DXW)
  ) u_heading (
    .clk    (clk),
    .dx     (s3_dx),
    .dy     (s3_dy),
    .heading(hdg_raw)
  );

  // S4: fit shifts, saturated slopes, side data
  logic [KW-1:0]         s4_k1, s4_k2;
  logic signed [DXW-1:0] s4_dx, s4_dy;
  logic signed [DDW-1:0] s4_ddx, s4_ddy;
  logic [SIDE_W-1:0]     s4_side;

  always_ff @(posedge clk) begin
    s4_k1   <= fit_k(mag_dx(s3_dx) | mag_dx(s3_dy));
    s4_k2   <= fit_k(mag_dd(s3_ddx) | mag_dd(s3_ddy));
    s4_dx   <= s3_dx;
    s4_dy   <= s3_dy;
    s4_ddx  <= s3_ddx;
    s4_ddy  <= s3_ddy;
    s4_side <= {fit_k(mag_dx(s3_dx) | mag_dx(s3_dy)),
                fit_k(mag_dd(s3_ddx) | mag_dd(s3_ddy)),
                s3_px, s3_py, sat_slope(s3_dx), sat_slope(s3_dy),
                (s3_dx == '0) && (s3_dy == '0)};
  end

  // S5: floor to 25-bit signed operands
  logic signed [AW-1:0] s5_ax, s5_ay, s5_bx, s5_by;

  always_ff @(posedge clk) begin
    s5_ax <= AW'(s4_dx >>> s4_k1);
    s5_ay <= AW'(s4_dy >>> s4_k1);
    s5_bx <= AW'(s4_ddx >>> s4_k2);
    s5_by <= AW'(s4_ddy >>> s4_k2);
  end

  // S6: products
  logic signed [NW-1:0] s6_pab, s6_pba, s6_paa, s6_pbb;

  always_ff @(posedge clk) begin
    s6_pab <= s5_ax * s5_by;
    s6_pba <= s5_ay * s5_bx;
    s6_paa <= s5_ax * s5_ax;
    s6_pbb <= s5_ay * s5_ay;
  end

  // S7: |cross| and squared speed
  logic signed [NW:0] xprod;
  logic [NW-1:0]      s7_n, s7_s;

  assign xprod = {s6_pab[NW-1], s6_pab} - {s6_pba[NW-1], s6_pba};

  always_ff @(posedge clk) begin
    s7_n <= xprod[NW] ? NW'(-xprod) : xprod[NW-1:0];
    s7_s <= NW'(s6_paa) + NW'(s6_pbb);
  end

  // T = floor(N*2^14 / S)
  logic [N1W-1:0]  num1;
  logic [T_QW-1:0] t_quo;

  assign num1 = {s7_n, T_SCALE'(0)};

  cbpe_div #(
    .QW (T_QW),
    .DVW(NW)
  ) u_div_t (
    .clk (clk),
    .rem0(NW'(num1 >> T_QW)),
    .low (num1[T_QW-1:0]),
    .dvs (s7_s),
    .quo (t_quo)
  );

  // R = isqrt(S*2^14), two radicand bits per stage
  logic [SQ_RW-1:0]    sq_rem  [SQ_STEPS];
  logic [N1W-1:0]      sq_v    [SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_root [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    logic [SQ_RW-1:0]    rem_in, sum, trial;
    logic [N1W-1:0]      v_in;
    logic [SQ_STEPS-1:0] root_in;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign v_in    = {s7_s, T_SCALE'(0)};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq_rem[i-1];
      assign v_in    = sq_v[i-1];
      assign root_in = sq_root[i-1];
    end

    assign sum   = {rem_in[SQ_RW-3:0], v_in[N1W-1 -: 2]};
    assign trial = SQ_RW'({root_in, 2'b01});
    assign ge    = (sum >= trial);

    always_ff @(posedge clk) begin
      sq_rem[i]  <= ge ? sum - trial : sum;
      sq_v[i]    <= v_in << 2;
      sq_root[i] <= {root_in[SQ_STEPS-2:0], ge};
    end
  end

  // align R with T
  logic [SQ_STEPS-1:0] r_dly [R_DLY];

  always_ff @(posedge clk) begin
    r_dly[0] <= sq_root[SQ_STEPS-1];
    for (int i = 1; i < R_DLY; i++) begin
      r_dly[i] <= r_dly[i-1];
    end
  end

  // q = floor(T*2^17 / R)
  logic [N2W-1:0]  num2;
  logic [Q_QW-1:0] q_quo;

  assign num2 = {t_quo, Q_SCALE'(0)};

  cbpe_div #(
    .QW (Q_QW),
    .DVW(SQ_STEPS)
  ) u_div_q (
    .clk (clk),
    .rem0(SQ_STEPS'(num2 >> Q_QW)),
    .low (num2[Q_QW-1:0]),
    .dvs (r_dly[R_DLY-1]),
    .quo (q_quo)
  );

  // Side data and heading delay lines
  logic [SIDE_W-1:0]        side_dly [SIDE_DLY];
  logic signed [HEAD_W-1:0] hdg_dly  [HEAD_DLY];

  always_ff @(posedge clk) begin
    side_dly[0] <= s4_side;
    for (int i = 1; i < SIDE_DLY; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
    hdg_dly[0] <= hdg_raw;
    for (int i = 1; i < HEAD_DLY; i++) begin
      hdg_dly[i] <= hdg_dly[i-1];
    end
  end

  logic [KW-1:0]              o_k1, o_k2;
  logic signed [W-1:0]        o_px, o_py;
  logic signed [SLOPE_W-1:0]  o_sx, o_sy;
  logic                       o_degen;

  assign {o_k1, o_k2, o_px, o_py, o_sx, o_sy, o_degen} = side_dly[SIDE_DLY-1];

  // Scale q by 2^(k2 - 2*k1) and saturate
  logic [KW:0]       k1x2, dsh;
  logic [Q_QW-1:0]   q_dn;
  logic [CURV_W-1:0] curv;

  always_comb begin
    k1x2 = {o_k1, 1'b0};
    dsh  = '0;
    q_dn = '0;
    curv = '0;
    if ({1'b0, o_k2} >= k1x2) begin
      dsh = {1'b0, o_k2} - k1x2;
      if (dsh >= (KW+1)'(CURV_W)) begin
        curv = (q_quo != '0) ? CURV_MAX : '0;
      end else if ((q_quo >> ((KW+1)'(CURV_W) - dsh)) != '0) begin
        curv = CURV_MAX;
      end else begin
        curv = CURV_W'(q_quo << dsh);
      end
    end else begin
      dsh  = k1x2 - {1'b0, o_k2};
      q_dn = q_quo >> dsh;
      curv = (q_dn > Q_QW'(CURV_MAX)) ? CURV_MAX : CURV_W'(q_dn);
    end
    if (o_degen) begin
      curv = CURV_MAX;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    pos_x         <= o_px;
    pos_y         <= o_py;
    slope_x       <= o_sx;
    slope_y       <= o_sy;
    heading       <= hdg_dly[HEAD_DLY-1];
    curvature_mag <= curv;
    degenerate    <= o_degen;
  end

  assign done = vld[TOTAL-1];

  // Checks
  a_degen_curv: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> curvature_mag == CURV_MAX)
    else $error("degenerate result without saturated curvature");

  a_degen_slope: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> slope_x == '0 && slope_y == '0)
    else $error("degenerate flag with nonzero slope");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    done |-> heading <= 16'sd23040 && heading >= -16'sd23040)
    else $error("heading out of range");

  a_done_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL))
    else $error("result strobe without a matching start");

endmodule
